/* design/rc4_stream_cipher_assert.svh */
// assertion macros for the rc4 stream cipher rtl
// included by modules that check their own sequencing; no other dependencies
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS
`define RC4_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rc4 assertion failed");
`define RC4_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rc4 assertion failed");
`define RC4_ASSERT_D3(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##3 (post)) \
    else $error("rc4 assertion failed");
`else
`define RC4_ASSERT_IMP(name, clk, rst_n, pre, post)
`define RC4_ASSERT_NXT(name, clk, rst_n, pre, post)
`define RC4_ASSERT_D3(name, clk, rst_n, pre, post)
`endif

`endif

/* design/rc4_pkg.sv */
`timescale 1ns / 1ps
// types and constants shared by the rc4 stream cipher rtl
// no dependencies
package rc4_pkg;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_INIT = 2'd1,
    OP_DATA = 2'd2,
    OP_SKIP = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_K4,
    ST_DSET,
    ST_PB,
    ST_PC,
    ST_PD,
    ST_EMIT
  } state_e;

  localparam int unsigned CFG_AW = 3;

  localparam logic REG_KSA_PASSES = 1'b0;
  localparam logic REG_DROP_COUNT = 1'b1;

  localparam logic [7:0]  KSA_PASSES_RST = 8'd1;
  localparam logic [15:0] DROP_COUNT_RST = 16'd0;

endpackage

/* design/rc4_ram.sv */
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// read-first on a same-address write; no dependencies
module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rc4_stream_cipher.sv */
`timescale 1ns / 1ps
// rc4 drop-n stream cipher engine: key store, key schedule, keystream sequencer
// depends on rc4_pkg, rc4_ram and rc4_stream_cipher_assert.svh
// key byte: written to the key ram until KEY_MAX bytes are held. data byte: one keystream step.
// skip of n bytes: n keystream steps. init: fill, ksa_passes schedule passes, drop_count steps.
// each keystream step walks ST_PB, ST_PC, ST_PD on the single read port of the permutation ram.
// after reset the ST_CLEAR pass loads the identity permutation while input is stalled.
`include "rc4_stream_cipher_assert.svh"

module rc4_stream_cipher #(
  parameter int unsigned KEY_MAX = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  rc4_pkg::opcode_e          opcode_i,
  input  logic [7:0]                byte_in_i,
  input  logic [15:0]               skip_count_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                byte_out_o,
  output logic [31:0]               stream_position_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rc4_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import rc4_pkg::*;

  localparam int unsigned KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned LW = $clog2(KEY_MAX + 1);

  state_e         state_q, state_d;
  logic [7:0]     k_q, k_d;
  logic [7:0]     pass_q, pass_d;
  logic [KW-1:0]  ki_q, ki_d;
  logic [7:0]     i_q, i_d;
  logic [7:0]     j_q, j_d;
  logic [7:0]     si_q, si_d;
  logic [7:0]     t_q, t_d;
  logic [7:0]     res_q, res_d;
  logic [7:0]     byte_q, byte_d;
  logic [15:0]    cnt_q, cnt_d;
  logic           loop_q, loop_d;
  logic [31:0]    pos_q, pos_d;
  logic [LW-1:0]  key_len_q, key_len_d;
  logic [7:0]     ksa_passes_q;
  logic [15:0]    drop_count_q;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q, out_byte_d;
  logic [31:0]    out_pos_q, out_pos_d;
  logic           fwd_we_q;
  logic [7:0]     fwd_addr_q;
  logic [7:0]     fwd_data_q;
  logic [7:0]     raddr_q;

  logic           s_we;
  logic [7:0]     s_waddr;
  logic [7:0]     s_wdata;
  logic [7:0]     s_raddr;
  logic [7:0]     s_rdata;
  logic [7:0]     s_rd;
  logic           k_we;
  logic [KW-1:0]  k_waddr;
  logic [7:0]     k_wdata;
  logic [KW-1:0]  k_raddr;
  logic [7:0]     k_rdata;

  logic [7:0]     add_a, add_b, add_c, add_sum;

  logic           in_acc;
  logic           acc_data;
  logic           out_free;
  logic           k_last;
  logic           pass_last;
  logic           cnt_last;
  logic           run_ksa;
  logic [7:0]     ks;
  logic [LW-1:0]  ki_ext;
  logic [KW-1:0]  ki_adv;
  logic           cfg_we;

  // permutation and key stores
  rc4_ram #(.WIDTH(8), .DEPTH(256)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  // shared index adder
  assign add_sum = add_a + add_b + add_c;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign acc_data   = in_acc && (opcode_i == OP_DATA);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign k_last     = (k_q == 8'hFF);
  assign pass_last  = (pass_q == ksa_passes_q - 8'd1);
  assign cnt_last   = (cnt_q == 16'd1);
  assign run_ksa    = (key_len_q != '0) && (ksa_passes_q != 8'd0);

  // forward a write that hit the address being read in the same cycle
  assign s_rd = (fwd_we_q && (fwd_addr_q == raddr_q)) ? fwd_data_q : s_rdata;
  // s[j] is written in the cycle after the keystream read was issued
  assign ks   = (t_q == j_q) ? si_q : s_rd;

  assign ki_ext = LW'(ki_q) + LW'(1);
  assign ki_adv = (ki_ext >= key_len_q) ? '0 : ki_ext[KW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (k_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_i)
            OP_KEY:  state_d = ST_IDLE;
            OP_INIT: state_d = ST_FILL;
            OP_DATA: state_d = ST_PB;
            OP_SKIP: state_d = (skip_count_i != 16'd0) ? ST_PB : ST_IDLE;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (k_last) state_d = run_ksa ? ST_K1 : ST_DSET;
      end
      ST_K1: state_d = ST_K2;
      ST_K2: state_d = ST_K3;
      ST_K3: state_d = ST_K4;
      ST_K4: state_d = (k_last && pass_last) ? ST_DSET : ST_K2;
      ST_DSET: state_d = (drop_count_q != 16'd0) ? ST_PB : ST_IDLE;
      ST_PB: state_d = ST_PC;
      ST_PC: state_d = ST_PD;
      ST_PD: begin
        if (loop_q) state_d = cnt_last ? ST_IDLE : ST_PB;
        else        state_d = out_free ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    k_d         = k_q;
    pass_d      = pass_q;
    ki_d        = ki_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    t_d         = t_q;
    res_d       = res_q;
    byte_d      = byte_q;
    cnt_d       = cnt_q;
    loop_d      = loop_q;
    pos_d       = pos_q;
    key_len_d   = key_len_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_pos_d   = out_pos_q;
    s_we        = 1'b0;
    s_waddr     = k_q;
    s_wdata     = k_q;
    s_raddr     = 8'd0;
    k_we        = 1'b0;
    k_waddr     = key_len_q[KW-1:0];
    k_wdata     = byte_in_i;
    k_raddr     = ki_q;
    add_a       = 8'd0;
    add_b       = 8'd0;
    add_c       = 8'd0;
    case (state_q)
      ST_CLEAR: begin
        s_we = 1'b1;
        k_d  = k_q + 8'd1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_i)
            OP_KEY: begin
              if (key_len_q < LW'(KEY_MAX)) begin
                k_we      = 1'b1;
                key_len_d = key_len_q + LW'(1);
              end
            end
            OP_INIT: begin
              k_d = 8'd0;
            end
            OP_DATA: begin
              add_a   = i_q;
              add_b   = 8'd1;
              i_d     = add_sum;
              s_raddr = add_sum;
              loop_d  = 1'b0;
              byte_d  = byte_in_i;
            end
            OP_SKIP: begin
              if (skip_count_i != 16'd0) begin
                add_a   = i_q;
                add_b   = 8'd1;
                i_d     = add_sum;
                s_raddr = add_sum;
                loop_d  = 1'b1;
                cnt_d   = skip_count_i;
                pos_d   = pos_q + 32'(skip_count_i);
              end
            end
            default: begin
              loop_d = loop_q;
            end
          endcase
        end
      end
      ST_FILL: begin
        s_we   = 1'b1;
        k_d    = k_q + 8'd1;
        pass_d = 8'd0;
        ki_d   = '0;
        j_d    = 8'd0;
      end
      ST_K1: begin
        s_raddr = k_q;
        k_raddr = ki_q;
      end
      ST_K2: begin
        add_a   = j_q;
        add_b   = s_rd;
        add_c   = k_rdata;
        j_d     = add_sum;
        s_raddr = add_sum;
        si_d    = s_rd;
      end
      ST_K3: begin
        s_we    = 1'b1;
        s_waddr = k_q;
        s_wdata = s_rd;
      end
      ST_K4: begin
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
        k_d     = k_q + 8'd1;
        s_raddr = k_q + 8'd1;
        if (k_last) begin
          ki_d    = '0;
          pass_d  = pass_q + 8'd1;
          k_raddr = '0;
        end else begin
          ki_d    = ki_adv;
          k_raddr = ki_adv;
        end
      end
      ST_DSET: begin
        pos_d     = 32'd0;
        key_len_d = '0;
        j_d       = 8'd0;
        if (drop_count_q != 16'd0) begin
          add_b   = 8'd1;
          i_d     = add_sum;
          s_raddr = add_sum;
          cnt_d   = drop_count_q;
          loop_d  = 1'b1;
        end else begin
          i_d = 8'd0;
        end
      end
      ST_PB: begin
        add_a   = j_q;
        add_b   = s_rd;
        j_d     = add_sum;
        s_raddr = add_sum;
        si_d    = s_rd;
      end
      ST_PC: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rd;
        add_a   = si_q;
        add_b   = s_rd;
        t_d     = add_sum;
        s_raddr = add_sum;
      end
      ST_PD: begin
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
        if (loop_q) begin
          cnt_d = cnt_q - 16'd1;
          if (!cnt_last) begin
            add_a   = i_q;
            add_b   = 8'd1;
            i_d     = add_sum;
            s_raddr = add_sum;
          end
        end else begin
          pos_d = pos_q + 32'd1;
          res_d = byte_q ^ ks;
          if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = byte_q ^ ks;
            out_pos_d   = pos_q + 32'd1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = res_q;
          out_pos_d   = pos_q;
        end
      end
      default: begin
        s_we = 1'b0;
      end
    endcase
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_KSA_PASSES: prdata = {24'd0, ksa_passes_q};
      REG_DROP_COUNT: prdata = {16'd0, drop_count_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksa_passes_q <= KSA_PASSES_RST;
      drop_count_q <= DROP_COUNT_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_KSA_PASSES) ksa_passes_q <= pwdata[7:0];
      else                            drop_count_q <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= 8'd0;
      pass_q      <= 8'd0;
      ki_q        <= '0;
      i_q         <= 8'd0;
      j_q         <= 8'd0;
      cnt_q       <= 16'd0;
      loop_q      <= 1'b0;
      pos_q       <= 32'd0;
      key_len_q   <= '0;
      out_valid_q <= 1'b0;
      fwd_we_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      pass_q      <= pass_d;
      ki_q        <= ki_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      loop_q      <= loop_d;
      pos_q       <= pos_d;
      key_len_q   <= key_len_d;
      out_valid_q <= out_valid_d;
      fwd_we_q    <= s_we;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    t_q        <= t_d;
    res_q      <= res_d;
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
    out_pos_q  <= out_pos_d;
    fwd_addr_q <= s_waddr;
    fwd_data_q <= s_wdata;
    raddr_q    <= s_raddr;
  end

  assign out_valid_o       = out_valid_q;
  assign byte_out_o        = out_byte_q;
  assign stream_position_o = out_pos_q;

  `RC4_ASSERT_D3(a_data_latency, clk_i, rst_ni, acc_data, (state_q == ST_PD) && !loop_q)
  `RC4_ASSERT_NXT(a_emit_hold, clk_i, rst_ni, (state_q == ST_PD) && !loop_q && !out_free, state_q == ST_EMIT)
  `RC4_ASSERT_IMP(a_loop_count, clk_i, rst_ni, (state_q == ST_PD) && loop_q, cnt_q != 16'd0)
  `RC4_ASSERT_IMP(a_key_len, clk_i, rst_ni, 1'b1, key_len_q <= LW'(KEY_MAX))

endmodule
